### hw/rtl/fcpu_pkg.sv
// ----------------------------------------------------------------------------
// fcpu_pkg
// Shared types and constants of the four-register byte CPU core: memory
// sizes, opcode map, status codes and print kinds.
// ----------------------------------------------------------------------------
`default_nettype none

package fcpu_pkg;

    // Program ROM and data RAM sizes in bytes
    localparam int ROM_BYTES = 32768;
    localparam int RAM_BYTES = 65536;
    localparam int RAM_AW    = $clog2(RAM_BYTES);

    // Data and address widths
    localparam int WORD_W = 16;
    localparam int BYTE_W = 8;
    localparam int SUM_W  = WORD_W + 1;

    // Opcode map: first code of each group, last valid code and halt
    localparam logic [7:0] OP_ADD8     = 8'h00;
    localparam logic [7:0] OP_SUB8     = 8'h04;
    localparam logic [7:0] OP_INC      = 8'h08;
    localparam logic [7:0] OP_DEC      = 8'h0C;
    localparam logic [7:0] OP_MOV8     = 8'h10;
    localparam logic [7:0] OP_JMP      = 8'h14;
    localparam logic [7:0] OP_ADD16    = 8'h15;
    localparam logic [7:0] OP_SUB16    = 8'h19;
    localparam logic [7:0] OP_MOV16    = 8'h1D;
    localparam logic [7:0] OP_CMP      = 8'h21;
    localparam logic [7:0] OP_JZ       = 8'h22;
    localparam logic [7:0] OP_JNZ      = 8'h23;
    localparam logic [7:0] OP_LD       = 8'h24;
    localparam logic [7:0] OP_ST       = 8'h28;
    localparam logic [7:0] OP_PUTC     = 8'h2C;
    localparam logic [7:0] OP_IN_CHAR  = 8'h2D;
    localparam logic [7:0] OP_PUTD     = 8'h2E;
    localparam logic [7:0] OP_PUTB     = 8'h2F;
    localparam logic [7:0] OP_IN_DEC   = 8'h30;
    localparam logic [7:0] OP_IN_BIN   = 8'h31;
    localparam logic [7:0] OP_LAST     = 8'h31;
    localparam logic [7:0] OP_HALT     = 8'hFF;

    // Print kinds
    localparam logic [1:0] EK_CHAR = 2'd0;
    localparam logic [1:0] EK_DEC  = 2'd1;
    localparam logic [1:0] EK_BIN  = 2'd2;

    // Result status
    typedef enum logic [2:0] {
        ST_RUN       = 3'd0,
        ST_HALT      = 3'd1,
        ST_UNKNOWN   = 3'd2,
        ST_TRUNC     = 3'd3,
        ST_RAM_RANGE = 3'd4,
        ST_PC_ROM    = 3'd5
    } t_status;

endpackage

`default_nettype wire

### hw/rtl/fcpu_ram.sv
// ----------------------------------------------------------------------------
// fcpu_ram
// Generic single-write, single-read synchronous RAM with registered read.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module fcpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hw/rtl/four_register_byte_cpu_core.sv
// ----------------------------------------------------------------------------
// four_register_byte_cpu_core
// Executes one instruction per request against four 16-bit registers, a
// program counter, a zero flag and a byte-wide data RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one instruction request:
//   the opcode and the two bytes after it, fetched by the host at the last
//   reported next_pc, plus the host input byte used by the IN opcodes.
//   Output channel (o_out_valid / i_out_ready) returns one result per
//   request: status, next_pc, zero flag, print request and input-taken flag.
//   A request is registered into the execute stage at accept, together with
//   the data RAM read issued at accept; its result is registered in the
//   output register when the execute stage hands off.
//   Throughput: one request per cycle when the receiver keeps up. The two
//   stages are the RAM read at accept and execute/write-back; a load that
//   follows a store to the same byte is served by a forwarding register.
//   Reset: registers, PC, zero flag and stop bit clear at once; then the
//   data RAM is swept to zero, one byte per cycle over all RAM_BYTES
//   (65536) addresses, during which o_in_ready stays low.
//   Receiver stall: the result holds in the output register; one further
//   request may wait in the execute stage, then o_in_ready drops.
//   After any stop status, every later request reports halted and changes
//   nothing until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module four_register_byte_cpu_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Instruction requests
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_opcode,
    input  wire logic [7:0]  i_imm_low,
    input  wire logic [7:0]  i_imm_high,
    input  wire logic [7:0]  i_in_value,
    // Results
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_status,
    output logic [15:0]      o_next_pc,
    output logic             o_zero_flag,
    output logic             o_emit_valid,
    output logic [1:0]       o_emit_kind,
    output logic [15:0]      o_emit_value,
    output logic             o_took_input
);

    localparam int AW = fcpu_pkg::RAM_AW;
    localparam int WW = fcpu_pkg::WORD_W;
    localparam int BW = fcpu_pkg::BYTE_W;
    localparam int SW = fcpu_pkg::SUM_W;

    // Instruction length in bytes
    function automatic logic [1:0] op_bytes(input logic [7:0] op);
        logic [1:0] len;
        if (op < fcpu_pkg::OP_JMP) begin
            len = (op < fcpu_pkg::OP_INC || op >= fcpu_pkg::OP_MOV8) ? 2'd2 : 2'd1;
        end else if (op < fcpu_pkg::OP_PUTC) begin
            len = 2'd3;
        end else begin
            len = 2'd1;
        end
        return len;
    endfunction

    // ------------------------------------------------------------------
    // Architectural state
    // ------------------------------------------------------------------
    logic [WW-1:0] r_reg [4];
    logic [WW-1:0] r_pc;
    logic          r_zero;
    logic          r_stopped;

    // RAM clearing sweep after reset
    logic          r_clr;
    logic [AW-1:0] r_clr_addr;

    // Execute stage
    logic          r_s1_valid;
    logic [7:0]    r_s1_op;
    logic [7:0]    r_s1_imm_lo;
    logic [7:0]    r_s1_imm_hi;
    logic [7:0]    r_s1_inb;
    logic          r_fwd;
    logic [BW-1:0] r_fwd_data;

    // Output register
    logic                r_out_valid;
    fcpu_pkg::t_status   r_out_status;
    logic [WW-1:0]       r_out_pc;
    logic                r_out_zero;
    logic                r_out_emit;
    logic [1:0]          r_out_kind;
    logic [WW-1:0]       r_out_evalue;
    logic                r_out_took;

    // Handshake
    logic in_fire;
    logic s1_fire;
    logic out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && out_free;
    assign o_in_ready = !r_clr && (!r_s1_valid || s1_fire);
    assign in_fire    = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Data RAM
    // ------------------------------------------------------------------
    logic [WW-1:0] w_in_addr;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [BW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [BW-1:0] ram_rdata;

    logic          x_st_we;
    logic [WW-1:0] w_sel;
    logic [WW-1:0] w_imm16;

    assign w_in_addr = {i_imm_high, i_imm_low};
    assign ram_raddr = w_in_addr[AW-1:0];
    assign w_imm16   = {r_s1_imm_hi, r_s1_imm_lo};

    // Sweep zeros after reset, otherwise take the committing store
    assign ram_we    = r_clr || (s1_fire && x_st_we);
    assign ram_waddr = r_clr ? r_clr_addr : w_imm16[AW-1:0];
    assign ram_wdata = r_clr ? '0 : w_sel[BW-1:0];

    fcpu_ram #(
        .WIDTH (BW),
        .DEPTH (fcpu_pkg::RAM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_fire),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Execute
    // ------------------------------------------------------------------
    logic [1:0]        w_ridx;
    logic [SW-1:0]     w_pc_end;
    logic              w_ram_oob;
    logic [BW-1:0]     w_ld_data;

    fcpu_pkg::t_status x_status;
    logic [SW-1:0]     x_newpc;
    logic              x_reg_we;
    logic [1:0]        x_widx;
    logic [WW-1:0]     x_reg_val;
    logic              x_zero;
    logic              x_emit;
    logic [1:0]        x_kind;
    logic [WW-1:0]     x_evalue;
    logic              x_took;
    logic              x_stop;

    // Register field: low two opcode bits, shifted by one in the groups
    // that start one past a multiple of four
    assign w_ridx = (r_s1_op < fcpu_pkg::OP_JMP || r_s1_op >= fcpu_pkg::OP_LD)
                  ? r_s1_op[1:0] : r_s1_op[1:0] - 2'd1;
    assign w_sel     = r_reg[w_ridx];
    assign w_pc_end  = {1'b0, r_pc} + SW'(op_bytes(r_s1_op));
    assign w_ram_oob = {1'b0, w_imm16} >= SW'(fcpu_pkg::RAM_BYTES);
    assign w_ld_data = r_fwd ? r_fwd_data : ram_rdata;

    always_comb begin
        x_status  = fcpu_pkg::ST_RUN;
        x_newpc   = {1'b0, r_pc};
        x_reg_we  = 1'b0;
        x_widx    = w_ridx;
        x_reg_val = '0;
        x_zero    = r_zero;
        x_emit    = 1'b0;
        x_kind    = fcpu_pkg::EK_CHAR;
        x_evalue  = '0;
        x_took    = 1'b0;
        x_st_we   = 1'b0;
        x_stop    = 1'b0;
        if (r_stopped) begin
            x_status = fcpu_pkg::ST_HALT;
        end else if (r_s1_op == fcpu_pkg::OP_HALT) begin
            x_status = fcpu_pkg::ST_HALT;
            x_stop   = 1'b1;
        end else if (r_s1_op > fcpu_pkg::OP_LAST) begin
            x_status = fcpu_pkg::ST_UNKNOWN;
            x_stop   = 1'b1;
        end else if (w_pc_end > SW'(fcpu_pkg::ROM_BYTES)) begin
            x_status = fcpu_pkg::ST_TRUNC;
            x_stop   = 1'b1;
        end else begin
            x_newpc = w_pc_end;
            unique case (r_s1_op) inside
                [fcpu_pkg::OP_ADD8 : fcpu_pkg::OP_ADD8 + 8'd3]: begin
                    x_reg_we  = 1'b1;
                    x_reg_val = w_sel + {8'h00, r_s1_imm_lo};
                end
                [fcpu_pkg::OP_SUB8 : fcpu_pkg::OP_SUB8 + 8'd3]: begin
                    x_reg_we  = 1'b1;
                    x_reg_val = w_sel - {8'h00, r_s1_imm_lo};
                end
                [fcpu_pkg::OP_INC : fcpu_pkg::OP_INC + 8'd3]: begin
                    x_reg_we  = 1'b1;
                    x_reg_val = w_sel + WW'(1);
                end
                [fcpu_pkg::OP_DEC : fcpu_pkg::OP_DEC + 8'd3]: begin
                    x_reg_we  = 1'b1;
                    x_reg_val = w_sel - WW'(1);
                end
                [fcpu_pkg::OP_MOV8 : fcpu_pkg::OP_MOV8 + 8'd3]: begin
                    x_reg_we  = 1'b1;
                    x_reg_val = {8'h00, r_s1_imm_lo};
                end
                fcpu_pkg::OP_JMP: begin
                    x_newpc = {1'b0, w_imm16};
                end
                [fcpu_pkg::OP_ADD16 : fcpu_pkg::OP_ADD16 + 8'd3]: begin
                    x_reg_we  = 1'b1;
                    x_reg_val = w_sel + w_imm16;
                end
                [fcpu_pkg::OP_SUB16 : fcpu_pkg::OP_SUB16 + 8'd3]: begin
                    x_reg_we  = 1'b1;
                    x_reg_val = w_sel - w_imm16;
                end
                [fcpu_pkg::OP_MOV16 : fcpu_pkg::OP_MOV16 + 8'd3]: begin
                    x_reg_we  = 1'b1;
                    x_reg_val = w_imm16;
                end
                fcpu_pkg::OP_CMP: begin
                    x_zero = (r_reg[0] == w_imm16);
                end
                fcpu_pkg::OP_JZ: begin
                    if (r_zero) begin
                        x_newpc = {1'b0, w_imm16};
                    end
                end
                fcpu_pkg::OP_JNZ: begin
                    if (!r_zero) begin
                        x_newpc = {1'b0, w_imm16};
                    end
                end
                [fcpu_pkg::OP_LD : fcpu_pkg::OP_ST + 8'd3]: begin
                    if (w_ram_oob) begin
                        // Out-of-range address: stop without side effects
                        x_status = fcpu_pkg::ST_RAM_RANGE;
                        x_stop   = 1'b1;
                        x_newpc  = {1'b0, r_pc};
                    end else if (r_s1_op < fcpu_pkg::OP_ST) begin
                        x_reg_we  = 1'b1;
                        x_reg_val = {8'h00, w_ld_data};
                    end else begin
                        x_st_we = 1'b1;
                    end
                end
                fcpu_pkg::OP_PUTC: begin
                    x_emit   = 1'b1;
                    x_kind   = fcpu_pkg::EK_CHAR;
                    x_evalue = {8'h00, r_reg[0][BW-1:0]};
                end
                fcpu_pkg::OP_PUTD: begin
                    x_emit   = 1'b1;
                    x_kind   = fcpu_pkg::EK_DEC;
                    x_evalue = r_reg[0];
                end
                fcpu_pkg::OP_PUTB: begin
                    x_emit   = 1'b1;
                    x_kind   = fcpu_pkg::EK_BIN;
                    x_evalue = {8'h00, r_reg[0][BW-1:0]};
                end
                fcpu_pkg::OP_IN_CHAR, fcpu_pkg::OP_IN_DEC, fcpu_pkg::OP_IN_BIN: begin
                    x_reg_we  = 1'b1;
                    x_widx    = 2'd0;
                    x_reg_val = {8'h00, r_s1_inb};
                    x_took    = 1'b1;
                end
                default: begin
                end
            endcase
            // Effects stand, but the new PC leaves the ROM
            if (x_status == fcpu_pkg::ST_RUN && x_newpc >= SW'(fcpu_pkg::ROM_BYTES)) begin
                x_status = fcpu_pkg::ST_PC_ROM;
                x_stop   = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(fcpu_pkg::RAM_BYTES - 1)) begin
                r_clr <= 1'b0;
            end
        end
    end

    // Architectural state: commit when the execute stage hands off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_reg[i] <= '0;
            end
            r_pc      <= '0;
            r_zero    <= 1'b0;
            r_stopped <= 1'b0;
        end else if (s1_fire) begin
            if (x_reg_we) begin
                r_reg[x_widx] <= x_reg_val;
            end
            r_pc      <= x_newpc[WW-1:0];
            r_zero    <= x_zero;
            r_stopped <= r_stopped || x_stop;
        end
    end

    // Execute stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Execute stage payload; capture a store hitting the byte being read
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_op     <= i_opcode;
            r_s1_imm_lo <= i_imm_low;
            r_s1_imm_hi <= i_imm_high;
            r_s1_inb    <= i_in_value;
            r_fwd       <= ram_we && (ram_waddr == ram_raddr);
            r_fwd_data  <= ram_wdata;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_status <= x_status;
            r_out_pc     <= x_newpc[WW-1:0];
            r_out_zero   <= x_zero;
            r_out_emit   <= x_emit;
            r_out_kind   <= x_kind;
            r_out_evalue <= x_evalue;
            r_out_took   <= x_took;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_next_pc    = r_out_pc;
    assign o_zero_flag  = r_out_zero;
    assign o_emit_valid = r_out_emit;
    assign o_emit_kind  = r_out_kind;
    assign o_emit_value = r_out_evalue;
    assign o_took_input = r_out_took;

endmodule

`default_nettype wire

### hw/rtl/fcpu_checker.sv
// ----------------------------------------------------------------------------
// fcpu_checker
// Port-level checks of the byte CPU core, bound into every core instance.
// ----------------------------------------------------------------------------
`default_nettype none

module fcpu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic [7:0]  i_opcode,
    input wire logic [7:0]  i_imm_low,
    input wire logic [7:0]  i_imm_high,
    input wire logic [7:0]  i_in_value,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  o_status,
    input wire logic [15:0] o_next_pc,
    input wire logic        o_zero_flag,
    input wire logic        o_emit_valid,
    input wire logic [1:0]  o_emit_kind,
    input wire logic [15:0] o_emit_value,
    input wire logic        o_took_input
);

    logic        r_stop_seen;
    logic [15:0] r_last_pc;
    logic        r_last_zero;
    logic        out_fire;

    assign out_fire = o_out_valid && i_out_ready;

    // Track the first stop result seen on the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_seen <= 1'b0;
        end else if (out_fire && o_status != fcpu_pkg::ST_RUN) begin
            r_stop_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire) begin
            r_last_pc   <= o_next_pc;
            r_last_zero <= o_zero_flag;
        end
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_next_pc))
        else $error("stalled result changed");

    // After a stop, every result is halted with frozen PC and flag
    a_stay_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_stop_seen |->
            o_status == fcpu_pkg::ST_HALT && o_next_pc == r_last_pc
            && o_zero_flag == r_last_zero)
        else $error("state changed after stop");

    // A print only comes from an executed instruction
    a_emit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_emit_valid |->
            o_status == fcpu_pkg::ST_RUN || o_status == fcpu_pkg::ST_PC_ROM)
        else $error("print with stop status");

    // Unused print fields read zero
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_emit_valid |->
            o_emit_kind == fcpu_pkg::EK_CHAR && o_emit_value == 16'h0000)
        else $error("idle print fields not zero");

    // No instruction both prints and reads input
    a_emit_or_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_emit_valid && o_took_input))
        else $error("print and input in one result");

endmodule

bind four_register_byte_cpu_core fcpu_checker u_fcpu_checker (.*);

`default_nettype wire
